[src/ldfr_pkg.sv]
// ----------------------------------------------------------------------------
// Launch detect flight recorder package
// Shared widths, register codes, reset values and the structs that travel
// between the recorder core and the result sequencer.
// ----------------------------------------------------------------------------
package ldfr_pkg;

    // Field widths of the input and result items.
    localparam int ALT_W      = 16;
    localparam int SUP_W      = 10;
    localparam int THR_W      = 16;
    localparam int LIM_W      = 9;   // slot limit and slot counter, up to 256
    localparam int WSLOT_W    = 8;   // slot index as written to the log

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_WINDOW_DEPTH = 5;
    localparam int DEF_MAX_SLOTS    = 256;

    // Largest slot count the 8-bit slot index can address.
    localparam int SLOT_CAP_MAX = 256;

    // Register reset values.
    localparam logic [THR_W-1:0] RST_LAUNCH_THRESHOLD = 16'd5;
    localparam logic [SUP_W-1:0] RST_BATTERY_LIMIT    = 10'd563;
    localparam logic [LIM_W-1:0] RST_LOG_SLOTS        = 9'd250;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAUNCH_THRESHOLD = 2'd0,
        CFG_BATTERY_LIMIT    = 2'd1,
        CFG_LOG_SLOTS        = 2'd2
    } t_cfg_idx;

    // Current configuration register contents.
    typedef struct packed {
        logic [THR_W-1:0] launch_threshold;
        logic [SUP_W-1:0] battery_limit;
        logic [LIM_W-1:0] log_slots;
    } t_cfg;

    // Result descriptor handed from the core to the sequencer for one item.
    typedef struct packed {
        logic               burst;       // launch item: emit the whole window
        logic               write_valid; // single result carries a log write
        logic [WSLOT_W-1:0] write_slot;
        logic [ALT_W-1:0]   write_data;
        logic               launched;
        logic               low_battery;
        logic               done_res;
    } t_desc;

endpackage

[src/launch_detect_flight_recorder_top.sv]
// ----------------------------------------------------------------------------
// Launch detect flight recorder
// Watches altitude for launch, logs the pre-launch window and later samples
// to consecutive slots up to the slot limit; latches low battery pre-launch.
//
//   channel  | direction | tdata (low bit up)                      | tuser/tlast
//   s_axis   | in        | altitude[15:0], supply_reading[25:16]   | -
//   m_axis   | out       | write_slot[7:0], write_data[23:8],      | tuser = write_valid
//            |           | launched[24], low_battery[25],          | tlast = last
//            |           | done_res[26]                            |
//   cfg      | in        | index 0 threshold, 1 battery limit, 2 log slots
//
// One item per cycle is accepted while m_axis takes results; each item
// passes through the input register and then sits in the result register
// until taken. The launch item gives WINDOW_DEPTH results, so the result
// register holds it until all are taken; the input side waits behind it.
// Reset is synchronous and clears all flags, the window and the slot counter.
// A stall on m_axis backs up through the result and input registers.
// ----------------------------------------------------------------------------
module launch_detect_flight_recorder_top
    import ldfr_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items: altitude[15:0], supply_reading[25:16]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // Result items: write_slot[7:0], write_data[23:8], launched[24],
    // low_battery[25], done_res[26]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tlast,
    // tuser: write_valid[0]
    output logic                  m_axis_tuser,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg               r_cfg;
    t_desc              w_desc;
    logic               w_desc_free;
    logic               w_desc_load;
    logic [ALT_W-1:0]   w_window [WINDOW_DEPTH];
    logic               w_write_valid;
    logic [WSLOT_W-1:0] w_write_slot;
    logic [ALT_W-1:0]   w_write_data;
    logic               w_launched;
    logic               w_low_battery;
    logic               w_done_res;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.launch_threshold <= RST_LAUNCH_THRESHOLD;
            r_cfg.battery_limit    <= RST_BATTERY_LIMIT;
            r_cfg.log_slots        <= RST_LOG_SLOTS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LAUNCH_THRESHOLD: r_cfg.launch_threshold <= i_cfg_data[THR_W-1:0];
                CFG_BATTERY_LIMIT:    r_cfg.battery_limit    <= i_cfg_data[SUP_W-1:0];
                CFG_LOG_SLOTS:        r_cfg.log_slots        <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    ldfr_core #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_SLOTS    (MAX_SLOTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (s_axis_tvalid),
        .i_alt       (s_axis_tdata[ALT_W-1:0]),
        .i_supply    (s_axis_tdata[ALT_W+SUP_W-1:ALT_W]),
        .i_desc_free (w_desc_free),
        .o_in_ready  (s_axis_tready),
        .o_desc_load (w_desc_load),
        .o_desc      (w_desc),
        .o_window    (w_window)
    );

    ldfr_burst #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_desc_load),
        .i_desc        (w_desc),
        .i_window      (w_window),
        .i_ready       (m_axis_tready),
        .o_free        (w_desc_free),
        .o_valid       (m_axis_tvalid),
        .o_write_valid (w_write_valid),
        .o_write_slot  (w_write_slot),
        .o_write_data  (w_write_data),
        .o_last        (m_axis_tlast),
        .o_launched    (w_launched),
        .o_low_battery (w_low_battery),
        .o_done_res    (w_done_res)
    );

    // Pack the result item.
    assign m_axis_tuser = w_write_valid;
    assign m_axis_tdata = {
        {(M_TDATA_W - WSLOT_W - ALT_W - 3){1'b0}},
        w_done_res, w_low_battery, w_launched, w_write_data, w_write_slot
    };

    // Recording can only be finished after launch.
    a_done_after_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_done_res |-> w_launched)
        else $error("done flag set without launch");

    // A status-only result carries zero slot and data.
    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (w_write_slot == '0) && (w_write_data == '0))
        else $error("status result carries slot or data");

    // Only the launch run has results before the last, and all of them are writes.
    a_run_is_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser && w_launched)
        else $error("non-final result outside the launch run");

    // The launched flag on results never falls once seen.
    a_launch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && w_launched ##1 m_axis_tvalid |-> w_launched)
        else $error("launched flag dropped");

endmodule

[src/ldfr_core.sv]
// ----------------------------------------------------------------------------
// Launch detect flight recorder core
// Input register, altitude window, launch detection, slot counting and the
// sticky flags. Produces one result descriptor per item.
// ----------------------------------------------------------------------------
module ldfr_core
    import ldfr_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    input  logic [ALT_W-1:0] i_alt,
    input  logic [SUP_W-1:0] i_supply,
    input  logic             i_desc_free,
    output logic             o_in_ready,
    output logic             o_desc_load,
    output t_desc            o_desc,
    output logic [ALT_W-1:0] o_window [WINDOW_DEPTH]
);

    localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_CAP = (MAX_SLOTS < SLOT_CAP_MAX) ? MAX_SLOTS : SLOT_CAP_MAX;

    // Input register.
    logic             r_in_valid;
    logic [ALT_W-1:0] r_alt;
    logic [SUP_W-1:0] r_supply;

    // Recorder state.
    logic [ALT_W-1:0]  r_window [WINDOW_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic              r_launched;
    logic              r_low_battery;
    logic [LIM_W-1:0]  r_next_slot;
    logic              r_full;

    logic [FILL_W-1:0] n_fill;
    logic              n_launched;
    logic              n_low_battery;
    logic [LIM_W-1:0]  n_next_slot;
    logic              n_full;
    logic              w_advance;
    logic              w_launch_now;
    logic              w_write;
    logic [LIM_W-1:0]  w_lim_cap;
    logic [LIM_W-1:0]  w_lim;
    logic [ALT_W:0]    w_oldest_plus;

    // The input register moves on whenever the sequencer can take a descriptor.
    assign w_advance   = r_in_valid && i_desc_free;
    assign o_in_ready  = !r_in_valid || i_desc_free;
    assign o_desc_load = w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_alt    <= i_alt;
            r_supply <= i_supply;
        end
    end

    // Effective slot limit: log_slots clamped to the window depth and the cap.
    assign w_lim_cap = (i_cfg.log_slots > LIM_W'(SLOT_CAP)) ? LIM_W'(SLOT_CAP)
                                                           : i_cfg.log_slots;
    assign w_lim     = (w_lim_cap < LIM_W'(WINDOW_DEPTH)) ? LIM_W'(WINDOW_DEPTH)
                                                         : w_lim_cap;

    // After the shift the oldest entry is the one currently at index 1.
    assign w_oldest_plus = {1'b0, r_window[1]} + {1'b0, i_cfg.launch_threshold};

    // Next state for the accepted item.
    always_comb begin
        n_fill        = r_fill;
        n_launched    = r_launched;
        n_low_battery = r_low_battery;
        n_next_slot   = r_next_slot;
        n_full        = r_full;
        w_launch_now  = 1'b0;
        w_write       = 1'b0;
        if (!r_launched) begin
            if (r_fill < FILL_W'(WINDOW_DEPTH)) begin
                n_fill = r_fill + 1'b1;
            end
            w_launch_now = (n_fill == FILL_W'(WINDOW_DEPTH)) &&
                           ({1'b0, r_alt} > w_oldest_plus);
            if (w_launch_now) begin
                n_launched  = 1'b1;
                n_next_slot = LIM_W'(WINDOW_DEPTH);
                n_full      = (LIM_W'(WINDOW_DEPTH) >= w_lim);
            end else if (r_supply >= i_cfg.battery_limit) begin
                n_low_battery = 1'b1;
            end
        end else begin
            w_write = !r_full && (r_next_slot < w_lim);
            if (w_write) begin
                n_next_slot = r_next_slot + 1'b1;
            end
            if (n_next_slot >= w_lim) begin
                n_full = 1'b1;
            end
        end
    end

    // State registers, updated once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_launched    <= 1'b0;
            r_low_battery <= 1'b0;
            r_next_slot   <= '0;
            r_full        <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_window[i] <= '0;
            end
        end else if (w_advance) begin
            r_fill        <= n_fill;
            r_launched    <= n_launched;
            r_low_battery <= n_low_battery;
            r_next_slot   <= n_next_slot;
            r_full        <= n_full;
            // The window shifts only before launch and then stays frozen.
            if (!r_launched) begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                    r_window[i] <= r_window[i + 1];
                end
                r_window[WINDOW_DEPTH - 1] <= r_alt;
            end
        end
    end

    // Descriptor for the sequencer.
    always_comb begin
        o_desc.burst       = w_launch_now;
        o_desc.write_valid = w_write;
        o_desc.write_slot  = w_write ? r_next_slot[WSLOT_W-1:0] : '0;
        o_desc.write_data  = w_write ? r_alt : '0;
        o_desc.launched    = n_launched;
        o_desc.low_battery = n_low_battery;
        o_desc.done_res    = n_full;
    end

    assign o_window = r_window;

endmodule

[src/ldfr_burst.sv]
// ----------------------------------------------------------------------------
// Launch detect flight recorder result sequencer
// Result register that presents one result per item, or the whole window as
// a run of log writes for the launch item.
// ----------------------------------------------------------------------------
module ldfr_burst
    import ldfr_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_desc              i_desc,
    input  logic [ALT_W-1:0]   i_window [WINDOW_DEPTH],
    input  logic               i_ready,
    output logic               o_free,
    output logic               o_valid,
    output logic               o_write_valid,
    output logic [WSLOT_W-1:0] o_write_slot,
    output logic [ALT_W-1:0]   o_write_data,
    output logic               o_last,
    output logic               o_launched,
    output logic               o_low_battery,
    output logic               o_done_res
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH);

    logic             r_valid;
    t_desc            r_desc;
    logic [CNT_W-1:0] r_cnt;

    // A descriptor is finished when its last result is taken.
    assign o_last  = !r_desc.burst || (r_cnt == CNT_W'(WINDOW_DEPTH - 1));
    assign o_free  = !r_valid || (i_ready && o_last);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (o_free) begin
            r_valid <= i_load;
            r_cnt   <= '0;
        end else if (i_ready) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_desc <= i_desc;
        end
    end

    // During the launch run the window is read oldest first; it is frozen then.
    always_comb begin
        if (r_desc.burst) begin
            o_write_valid = 1'b1;
            o_write_slot  = WSLOT_W'(r_cnt);
            o_write_data  = i_window[r_cnt];
        end else begin
            o_write_valid = r_desc.write_valid;
            o_write_slot  = r_desc.write_slot;
            o_write_data  = r_desc.write_data;
        end
    end

    assign o_launched    = r_desc.launched;
    assign o_low_battery = r_desc.low_battery;
    assign o_done_res    = r_desc.done_res;

endmodule
